/* hw/rtl/cle_pkg.sv */
`timescale 1ns / 1ps

package cle_pkg;

    // Number of entries in the store; entries are numbered 1..CAPACITY, 0 means none.
    localparam int CAPACITY = 1024;
    // Width of an entry number (must hold CAPACITY itself).
    localparam int IDX_W = $clog2(CAPACITY + 1);
    // Width of a memory address (entry number minus one).
    localparam int ADDR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    // Width of the start position register.
    localparam int START_W = 11;
    // The cursor holds any start position as well as any entry number.
    localparam int CUR_W = (IDX_W > START_W) ? IDX_W : START_W;
    // Width of a stored value.
    localparam int VAL_W = 32;

    // Configuration port.
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic [PADDR_W-3:0] REG_START_POSITION = '0;

    // Command codes.
    typedef enum logic [2:0] {
        FN_APPEND    = 3'd0,
        FN_PRINT     = 3'd1,
        FN_MOVE_L    = 3'd2,
        FN_MOVE_R    = 3'd3,
        FN_INS_L     = 3'd4,
        FN_INS_R     = 3'd5
    } t_func;

    // Result status codes.
    typedef enum logic [1:0] {
        SC_DONE      = 2'd0,
        SC_END       = 2'd1,
        SC_FULL      = 2'd2,
        SC_UNWRITTEN = 2'd3
    } t_status;

    // Command sequencer states.
    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_LINK
    } t_state;

    // Configuration handed from the register block to the sequencer.
    typedef struct packed {
        logic               load;
        logic [START_W-1:0] start;
    } t_cfg;

    // Maps an entry number to its memory address.
    function automatic logic [ADDR_W-1:0] ent2addr(input logic [IDX_W-1:0] e);
        logic [IDX_W-1:0] d;
        begin
            d = e - {{(IDX_W-1){1'b0}}, 1'b1};
            return d[ADDR_W-1:0];
        end
    endfunction

endpackage

/* hw/rtl/cle_ram.sv */
`timescale 1ns / 1ps

module cle_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                             i_clk,
    input  logic                             i_we,
    input  logic [$clog2(DEPTH)-1:0]         i_waddr,
    input  logic [WIDTH-1:0]                 i_wdata,
    input  logic                             i_re,
    input  logic [$clog2(DEPTH)-1:0]         i_raddr,
    output logic [WIDTH-1:0]                 o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port and one registered read port; read data holds until the next read.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* hw/rtl/cle_apb.sv */
`timescale 1ns / 1ps

module cle_apb (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [cle_pkg::PADDR_W-1:0]       paddr,
    input  logic [cle_pkg::PDATA_W-1:0]       pwdata,
    output logic [cle_pkg::PDATA_W-1:0]       prdata,
    output logic                              pready,
    output cle_pkg::t_cfg                     o_cfg
);

    logic [cle_pkg::START_W-1:0] r_start;
    logic                        hit;
    logic                        wr;

    // Register decode on the word index.
    assign hit = (paddr[cle_pkg::PADDR_W-1:2] == cle_pkg::REG_START_POSITION);
    assign wr  = psel && penable && pwrite && hit;

    // Start position register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start <= cle_pkg::START_W'(1);
        end else if (wr) begin
            r_start <= pwdata[cle_pkg::START_W-1:0];
        end
    end

    // Read data and the load strobe for the cursor.
    assign prdata = hit ? {{(cle_pkg::PDATA_W-cle_pkg::START_W){1'b0}}, r_start} : '0;
    assign pready = 1'b1;

    assign o_cfg.load  = wr;
    assign o_cfg.start = pwdata[cle_pkg::START_W-1:0];

endmodule

/* hw/rtl/cursor_linked_list_editor.sv */
`timescale 1ns / 1ps

// Doubly linked list editor with a cursor. Each command item (append, print,
// move left or right, insert left or right) yields exactly one result item
// with a read value and a status. Values and the two link fields live in
// three single-port-write memories with a registered read; the memories
// need no clearing after reset. A command reads the cursor entry, then
// executes once the result can be taken, with a further link step when it
// also relinks a neighbor (append to a non-empty list, either insert), since
// each link memory takes one write per cycle. Results wait in an output
// register; a new item is taken only once the previous item's memory writes
// are done. Writing start_position also moves the cursor to that entry.
module cursor_linked_list_editor (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Command channel.
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [2:0]                        i_func,
    input  logic signed [31:0]                i_new_value,
    // Result channel.
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic signed [31:0]                o_read_value,
    output logic [1:0]                        o_status,
    // Configuration port.
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [cle_pkg::PADDR_W-1:0]       paddr,
    input  logic [cle_pkg::PDATA_W-1:0]       pwdata,
    output logic [cle_pkg::PDATA_W-1:0]       prdata,
    output logic                              pready
);

    localparam int IDX_W  = cle_pkg::IDX_W;
    localparam int ADDR_W = cle_pkg::ADDR_W;
    localparam int CUR_W  = cle_pkg::CUR_W;
    localparam int VAL_W  = cle_pkg::VAL_W;

    cle_pkg::t_cfg   cfg;
    cle_pkg::t_state r_state, n_state;

    logic [2:0]        r_func;
    logic [VAL_W-1:0]  r_value;
    logic [CUR_W-1:0]  r_cursor, n_cursor;
    logic [IDX_W-1:0]  r_count, n_count;
    logic [IDX_W-1:0]  r_tail, n_tail;
    logic              r_out_valid, n_out_valid;
    logic [VAL_W-1:0]  r_read_value, n_read_value;
    cle_pkg::t_status  r_status, n_status;
    // Pending neighbor writes for the relink cycle.
    logic              r_pwe, n_pwe, r_nwe, n_nwe;
    logic [IDX_W-1:0]  r_pent, n_pent, r_pdat, n_pdat;
    logic [IDX_W-1:0]  r_nent, n_nent, r_ndat, n_ndat;

    // Memory ports.
    logic              mem_re;
    logic [ADDR_W-1:0] mem_raddr;
    logic              val_we, prv_we, nxt_we;
    logic [ADDR_W-1:0] val_wa, prv_wa, nxt_wa;
    logic [VAL_W-1:0]  val_wd, val_rd;
    logic [IDX_W-1:0]  prv_wd, nxt_wd, prv_rd, nxt_rd;

    // Execute-cycle helpers.
    logic              accept, out_ok, written, full, do_link;
    logic [IDX_W-1:0]  ent_new, cur_ent, nb;

    cle_apb u_apb (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    cle_ram #(.WIDTH(VAL_W), .DEPTH(cle_pkg::CAPACITY)) u_val_mem (
        .i_clk (i_clk), .i_we (val_we), .i_waddr (val_wa), .i_wdata (val_wd),
        .i_re (mem_re), .i_raddr (mem_raddr), .o_rdata (val_rd)
    );

    cle_ram #(.WIDTH(IDX_W), .DEPTH(cle_pkg::CAPACITY)) u_prev_mem (
        .i_clk (i_clk), .i_we (prv_we), .i_waddr (prv_wa), .i_wdata (prv_wd),
        .i_re (mem_re), .i_raddr (mem_raddr), .o_rdata (prv_rd)
    );

    cle_ram #(.WIDTH(IDX_W), .DEPTH(cle_pkg::CAPACITY)) u_next_mem (
        .i_clk (i_clk), .i_we (nxt_we), .i_waddr (nxt_wa), .i_wdata (nxt_wd),
        .i_re (mem_re), .i_raddr (mem_raddr), .o_rdata (nxt_rd)
    );

    // Handshakes: one item at a time, the cursor entry is read on accept.
    assign o_in_stall = (r_state != cle_pkg::S_IDLE);
    assign accept     = i_in_valid && (r_state == cle_pkg::S_IDLE);
    assign out_ok     = !r_out_valid || !i_out_stall;
    assign mem_re     = accept;
    assign mem_raddr  = cle_pkg::ent2addr(r_cursor[IDX_W-1:0]);

    // Cursor and store conditions.
    assign cur_ent = r_cursor[IDX_W-1:0];
    assign written = (r_cursor != '0) && (r_cursor <= CUR_W'(r_count));
    assign full    = (r_count == IDX_W'(cle_pkg::CAPACITY));
    assign ent_new = r_count + {{(IDX_W-1){1'b0}}, 1'b1};

    // Sequencer: execute the command, then do the neighbor writes if any.
    always_comb begin
        n_state      = r_state;
        n_cursor     = r_cursor;
        n_count      = r_count;
        n_tail       = r_tail;
        n_out_valid  = r_out_valid && i_out_stall;
        n_read_value = r_read_value;
        n_status     = r_status;
        n_pwe        = r_pwe;
        n_pent       = r_pent;
        n_pdat       = r_pdat;
        n_nwe        = r_nwe;
        n_nent       = r_nent;
        n_ndat       = r_ndat;
        val_we       = 1'b0;
        prv_we       = 1'b0;
        nxt_we       = 1'b0;
        val_wa       = cle_pkg::ent2addr(ent_new);
        prv_wa       = cle_pkg::ent2addr(ent_new);
        nxt_wa       = cle_pkg::ent2addr(ent_new);
        val_wd       = r_value;
        prv_wd       = '0;
        nxt_wd       = '0;
        nb           = '0;
        do_link      = 1'b0;

        case (r_state)
            cle_pkg::S_IDLE: begin
                if (accept) begin
                    n_state = cle_pkg::S_EXEC;
                end
            end

            cle_pkg::S_EXEC: begin
                if (out_ok) begin
                    n_out_valid  = 1'b1;
                    n_read_value = '0;
                    n_status     = cle_pkg::SC_DONE;
                    n_pwe        = 1'b0;
                    n_nwe        = 1'b0;
                    case (r_func)
                        cle_pkg::FN_APPEND: begin
                            if (full) begin
                                n_status = cle_pkg::SC_FULL;
                            end else begin
                                val_we  = 1'b1;
                                prv_we  = 1'b1;
                                prv_wd  = r_tail;
                                nxt_we  = 1'b1;
                                nxt_wd  = '0;
                                n_nwe   = (r_tail != '0);
                                n_nent  = r_tail;
                                n_ndat  = ent_new;
                                n_tail  = ent_new;
                                n_count = ent_new;
                            end
                        end
                        cle_pkg::FN_PRINT: begin
                            if (!written) begin
                                n_status = cle_pkg::SC_UNWRITTEN;
                            end else begin
                                n_read_value = val_rd;
                            end
                        end
                        cle_pkg::FN_MOVE_L, cle_pkg::FN_MOVE_R: begin
                            nb = (r_func == cle_pkg::FN_MOVE_L) ? prv_rd : nxt_rd;
                            if (!written) begin
                                n_status = cle_pkg::SC_UNWRITTEN;
                            end else if (nb == '0) begin
                                n_status = cle_pkg::SC_END;
                            end else begin
                                n_cursor = CUR_W'(nb);
                            end
                        end
                        cle_pkg::FN_INS_L: begin
                            if (!written) begin
                                n_status = cle_pkg::SC_UNWRITTEN;
                            end else if (full) begin
                                n_status = cle_pkg::SC_FULL;
                            end else begin
                                val_we  = 1'b1;
                                prv_we  = 1'b1;
                                prv_wd  = prv_rd;
                                nxt_we  = 1'b1;
                                nxt_wd  = cur_ent;
                                n_pwe   = 1'b1;
                                n_pent  = cur_ent;
                                n_pdat  = ent_new;
                                n_nwe   = (prv_rd != '0);
                                n_nent  = prv_rd;
                                n_ndat  = ent_new;
                                n_count = ent_new;
                            end
                        end
                        cle_pkg::FN_INS_R: begin
                            if (!written) begin
                                n_status = cle_pkg::SC_UNWRITTEN;
                            end else if (full) begin
                                n_status = cle_pkg::SC_FULL;
                            end else begin
                                val_we  = 1'b1;
                                prv_we  = 1'b1;
                                prv_wd  = cur_ent;
                                nxt_we  = 1'b1;
                                nxt_wd  = nxt_rd;
                                n_nwe   = 1'b1;
                                n_nent  = cur_ent;
                                n_ndat  = ent_new;
                                n_pwe   = (nxt_rd != '0);
                                n_pent  = nxt_rd;
                                n_pdat  = ent_new;
                                if (nxt_rd == '0) begin
                                    n_tail = ent_new;
                                end
                                n_count = ent_new;
                            end
                        end
                        default: begin
                            // Unused command codes answer done with no effect.
                        end
                    endcase
                    do_link = n_pwe || n_nwe;
                    n_state = do_link ? cle_pkg::S_LINK : cle_pkg::S_IDLE;
                end
            end

            cle_pkg::S_LINK: begin
                prv_we  = r_pwe;
                prv_wa  = cle_pkg::ent2addr(r_pent);
                prv_wd  = r_pdat;
                nxt_we  = r_nwe;
                nxt_wa  = cle_pkg::ent2addr(r_nent);
                nxt_wd  = r_ndat;
                n_pwe   = 1'b0;
                n_nwe   = 1'b0;
                n_state = cle_pkg::S_IDLE;
            end

            default: begin
                n_state = cle_pkg::S_IDLE;
            end
        endcase

        // A start position write reloads the cursor.
        if (cfg.load) begin
            n_cursor = CUR_W'(cfg.start);
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= cle_pkg::S_IDLE;
            r_cursor    <= CUR_W'(1);
            r_count     <= '0;
            r_tail      <= '0;
            r_out_valid <= 1'b0;
            r_pwe       <= 1'b0;
            r_nwe       <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cursor    <= n_cursor;
            r_count     <= n_count;
            r_tail      <= n_tail;
            r_out_valid <= n_out_valid;
            r_pwe       <= n_pwe;
            r_nwe       <= n_nwe;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_func  <= i_func;
            r_value <= i_new_value;
        end
        r_read_value <= n_read_value;
        r_status     <= n_status;
        r_pent       <= n_pent;
        r_pdat       <= n_pdat;
        r_nent       <= n_nent;
        r_ndat       <= n_ndat;
    end

    assign o_out_valid  = r_out_valid;
    assign o_read_value = r_read_value;
    assign o_status     = r_status;

endmodule
